// ===== rtl/sdol_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted draw-order list package
// Shared beat types, operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package sdol_pkg;

   // Operation codes carried on the request beat.
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_READOUT = 2'd2
   } op_type;

   // Status codes carried on the response beat.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // Sequencer states of the core.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_REQ,
      ST_RD_OUT,
      ST_RESP
   } state_type;

   // Request beat.
   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         object_id;
      logic [15:0]        depth_key;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [1:0]         status;
      logic               valid_res;
      logic [7:0]         out_id;
      logic [15:0]        out_depth;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/sdol_key_cmp.sv =====
// ----------------------------------------------------------------------------
// Sort key comparator
// Tells whether a stored entry sorts at or after a new entry, either by
// depth or by y position and then x position.
// ----------------------------------------------------------------------------
module sdol_key_cmp #(
   parameter int COORD_BITS = 16
) (
   input  logic                         sort_mode,
   input  logic [15:0]                  st_depth,
   input  logic signed [COORD_BITS-1:0] st_x,
   input  logic signed [COORD_BITS-1:0] st_y,
   input  logic [15:0]                  nw_depth,
   input  logic signed [COORD_BITS-1:0] nw_x,
   input  logic signed [COORD_BITS-1:0] nw_y,
   output logic                         at_or_after
);

   // Depth order is unsigned; position order is signed, y first.
   always_comb begin
      if (!sort_mode) begin
         at_or_after = (st_depth >= nw_depth);
      end else if (st_y != nw_y) begin
         at_or_after = (st_y > nw_y);
      end else begin
         at_or_after = (st_x >= nw_x);
      end
   end

endmodule

// ===== rtl/sorted_draw_order_list_core.sv =====
// ----------------------------------------------------------------------------
// Sorted draw-order list core
// Bounded sorted table of display entries kept in one memory and walked by
// a small sequencer with one shared key comparator.
// ----------------------------------------------------------------------------
// The table lives in a single-port-write, single-port-read memory with a
// registered read, so inserts, removes and readouts walk the stored entries.
// An insert or a remove makes one pipelined pass over them, then ST_RESP
// hands over its single response beat; a full-table insert and an empty
// readout go straight to ST_RESP, and an unknown op gets no response. A
// readout fetches one entry at a time via ST_RD_REQ and ST_RD_OUT, and
// stalls in ST_RD_OUT while rsp_ready holds the output. The core takes
// one request at a time: req_ready is high only while the sequencer is idle.
// The table needs no clearing after reset; only the count and control state are reset.
module sorted_draw_order_list_core #(
   parameter int ENTRIES    = 32,
   parameter int COORD_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdol_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdol_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int AW    = $clog2(ENTRIES);
   localparam int EW    = 8 + 16 + 2 * COORD_BITS;
   localparam int WIDE  = (COORD_BITS > 16) ? COORD_BITS : 16;
   // Field positions within a packed entry {id, depth, x, y}.
   localparam int Y_LO  = 0;
   localparam int X_LO  = COORD_BITS;
   localparam int D_LO  = 2 * COORD_BITS;
   localparam int ID_LO = 2 * COORD_BITS + 16;

   // Registers.
   sdol_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                sort_mode_ff;
   sdol_pkg::op_type    op_ff, op_in;
   logic [EW-1:0]       new_ff, new_in;
   logic [EW-1:0]       carry_ff, carry_in;
   logic                found_ff, found_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;
   sdol_pkg::rsp_type   pend_rsp_ff, pend_rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sdol_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [EW-1:0]       rd_data_ff;

   // Table memory.
   logic [EW-1:0]       entry_mem [ENTRIES];
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   logic [EW-1:0]       mem_wd;
   logic [AW-1:0]       rd_addr;

   // Helpers.
   logic [WIDE-1:0]              in_x_wide, in_y_wide;
   logic [COORD_BITS-1:0]        in_x, in_y;
   logic [EW-1:0]                req_entry;
   logic signed [COORD_BITS-1:0] rd_x, rd_y, nw_x, nw_y;
   logic signed [WIDE-1:0]       rd_x_wide, rd_y_wide;
   sdol_pkg::rsp_type            rd_rsp;
   logic                         hit;
   logic                         issue;
   logic                         out_free;

   // Input coordinates are taken as COORD_BITS-bit two's complement values.
   assign in_x_wide = WIDE'($unsigned(req_data.pos_x));
   assign in_y_wide = WIDE'($unsigned(req_data.pos_y));
   assign in_x      = in_x_wide[COORD_BITS-1:0];
   assign in_y      = in_y_wide[COORD_BITS-1:0];
   assign req_entry = {req_data.object_id, req_data.depth_key, in_x, in_y};

   // Unpack the entry just read and widen it into response fields.
   assign rd_x      = rd_data_ff[X_LO +: COORD_BITS];
   assign rd_y      = rd_data_ff[Y_LO +: COORD_BITS];
   assign nw_x      = new_ff[X_LO +: COORD_BITS];
   assign nw_y      = new_ff[Y_LO +: COORD_BITS];
   assign rd_x_wide = WIDE'(rd_x);
   assign rd_y_wide = WIDE'(rd_y);

   always_comb begin
      rd_rsp           = '0;
      rd_rsp.status    = sdol_pkg::STATUS_OK;
      rd_rsp.out_id    = rd_data_ff[ID_LO +: 8];
      rd_rsp.out_depth = rd_data_ff[D_LO +: 16];
      rd_rsp.out_x     = rd_x_wide[15:0];
      rd_rsp.out_y     = rd_y_wide[15:0];
   end

   // Shared key comparator: stored entry against the new entry.
   sdol_key_cmp #(
      .COORD_BITS (COORD_BITS)
   ) u_key_cmp (
      .sort_mode   (sort_mode_ff),
      .st_depth    (rd_data_ff[D_LO +: 16]),
      .st_x        (rd_x),
      .st_y        (rd_y),
      .nw_depth    (new_ff[D_LO +: 16]),
      .nw_x        (nw_x),
      .nw_y        (nw_y),
      .at_or_after (hit)
   );

   // The read address always follows the walk index.
   assign rd_addr  = idx_ff[AW-1:0];
   assign issue    = (idx_ff < count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Memory write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // Sequencer next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      new_in       = new_ff;
      carry_in     = carry_ff;
      found_in     = found_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      pend_rsp_in  = pend_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = pend_idx_ff;
      mem_wd       = carry_ff;
      req_ready    = 1'b0;

      case (state_ff)
         sdol_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = sdol_pkg::op_type'(req_data.op);
               new_in      = req_entry;
               carry_in    = req_entry;
               found_in    = 1'b0;
               idx_in      = '0;
               pend_rsp_in = '0;
               pend_rsp_in.last = 1'b1;
               case (sdol_pkg::op_type'(req_data.op))
                  sdol_pkg::OP_INSERT: begin
                     if (count_ff >= CW'(ENTRIES)) begin
                        pend_rsp_in.status = sdol_pkg::STATUS_FULL;
                        state_in = sdol_pkg::ST_RESP;
                     end else begin
                        state_in = sdol_pkg::ST_SCAN;
                     end
                  end
                  sdol_pkg::OP_REMOVE: begin
                     state_in = sdol_pkg::ST_SCAN;
                  end
                  sdol_pkg::OP_READOUT: begin
                     if (count_ff == '0) begin
                        state_in = sdol_pkg::ST_RESP;
                     end else begin
                        state_in = sdol_pkg::ST_RD_REQ;
                     end
                  end
                  default: begin
                     state_in = sdol_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         // One pipelined pass: issue a read each cycle, act on the entry
         // that arrived from the previous read.
         sdol_pkg::ST_SCAN: begin
            if (issue) begin
               idx_in      = idx_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (op_ff == sdol_pkg::OP_INSERT) begin
                  // From the insert point on, each entry moves up by one.
                  if (found_ff || hit) begin
                     found_in = 1'b1;
                     mem_we   = 1'b1;
                     mem_wa   = pend_idx_ff;
                     mem_wd   = carry_ff;
                     carry_in = rd_data_ff;
                  end
               end else begin
                  // Past the removed entry, each entry moves down by one.
                  if (found_ff) begin
                     mem_we = 1'b1;
                     mem_wa = pend_idx_ff - 1'b1;
                     mem_wd = rd_data_ff;
                  end else if (rd_data_ff[ID_LO +: 8] == new_ff[ID_LO +: 8]) begin
                     found_in    = 1'b1;
                     pend_rsp_in = rd_rsp;
                     pend_rsp_in.last = 1'b1;
                  end
               end
            end else if (!issue) begin
               // Pass is complete.
               if (op_ff == sdol_pkg::OP_INSERT) begin
                  mem_we   = 1'b1;
                  mem_wa   = count_ff[AW-1:0];
                  mem_wd   = carry_ff;
                  count_in = count_ff + 1'b1;
                  pend_rsp_in = '0;
                  pend_rsp_in.last = 1'b1;
               end else if (found_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  pend_rsp_in = '0;
                  pend_rsp_in.status = sdol_pkg::STATUS_NOT_FOUND;
                  pend_rsp_in.last   = 1'b1;
               end
               state_in = sdol_pkg::ST_RESP;
            end
         end

         // Readout: the read address is held while the entry waits.
         sdol_pkg::ST_RD_REQ: begin
            state_in = sdol_pkg::ST_RD_OUT;
         end

         sdol_pkg::ST_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in           = rd_rsp;
               rsp_data_in.valid_res = 1'b1;
               rsp_data_in.last      = (idx_ff + 1'b1 == count_ff);
               if (idx_ff + 1'b1 == count_ff) begin
                  state_in = sdol_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = sdol_pkg::ST_RD_REQ;
               end
            end
         end

         // Hand the single response beat to the output register.
         sdol_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_rsp_ff;
               state_in     = sdol_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sdol_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdol_pkg::ST_IDLE;
         count_ff     <= '0;
         sort_mode_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            sort_mode_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      new_ff      <= new_in;
      carry_ff    <= carry_in;
      found_ff    <= found_in;
      pend_idx_ff <= pend_idx_in;
      pend_rsp_ff <= pend_rsp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
